// ----- rtl/core/ber_tlv_pkg.sv -----
`default_nettype none

package ber_tlv_pkg;

  typedef enum logic [1:0] {
    PH_IDENT    = 2'd0,
    PH_TAG      = 2'd1,
    PH_LEN      = 2'd2,
    PH_LENBYTES = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TAG_LONG = 2'd1,
    ST_LEN_LONG = 2'd2
  } status_t;

  localparam logic [4:0] TAG_LONG_FORM   = 5'h1F;
  localparam logic [3:0] TAG_MAX_OCTETS  = 4'd10;
  localparam logic [6:0] LEN_MAX_BYTES   = 7'd8;
  localparam logic [6:0] LEN_INDEFINITE  = 7'd0;

  typedef struct packed {
    logic [1:0]  tag_class;
    logic        constructed;
    logic [62:0] tag_num;
    logic [63:0] content_length;
    logic        indefinite;
    status_t     status;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/core/ber_tlv_in_if.sv -----
`default_nettype none

interface ber_tlv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/ber_tlv_out_if.sv -----
`default_nettype none

interface ber_tlv_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  tag_class;
  logic        constructed;
  logic [62:0] tag_num;
  logic [63:0] content_length;
  logic        indefinite;
  logic [1:0]  status;

  modport source (output valid, output tag_class, output constructed, output tag_num,
                  output content_length, output indefinite, output status, input ready);
  modport sink (input valid, input tag_class, input constructed, input tag_num,
                input content_length, input indefinite, input status, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/ber_tlv_header_decoder.sv -----
// The final header octet passes the input register, then the output register driving out valid.
// Throughput: one octet per cycle while the output is not stalled; at most one result beat per header.
// The decode state machine sits between the input register and the output register.
// Reset (synchronous, active low) empties both registers and returns to identifier wait.
`default_nettype none

module ber_tlv_header_decoder
  import ber_tlv_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  ber_tlv_in_if.sink    in_bus,
  ber_tlv_out_if.source out_bus
);

  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       out_valid_r;
  result_t    res_r;
  logic       advance;
  logic       in_ready;
  logic       emit;
  result_t    res;

  assign advance  = !out_valid_r || out_bus.ready;
  assign in_ready = !s1_valid_r || advance;
  assign in_bus.ready = in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_bus.valid) begin
      s1_byte_r <= in_bus.data_byte;
    end
  end

  ber_tlv_fsm u_fsm (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (s1_valid_r && advance),
    .data_byte (s1_byte_r),
    .emit      (emit),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r && emit) begin
      res_r <= res;
    end
  end

  assign out_bus.valid          = out_valid_r;
  assign out_bus.tag_class      = res_r.tag_class;
  assign out_bus.constructed    = res_r.constructed;
  assign out_bus.tag_num        = res_r.tag_num;
  assign out_bus.content_length = res_r.content_length;
  assign out_bus.indefinite     = res_r.indefinite;
  assign out_bus.status         = res_r.status;

endmodule

`default_nettype wire

// ----- rtl/core/ber_tlv_fsm.sv -----
`default_nettype none

module ber_tlv_fsm
  import ber_tlv_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step,
  input  wire logic [7:0] data_byte,
  output logic            emit,
  output result_t         res
);

  phase_t      phase_r, phase_nxt;
  logic [1:0]  class_r, class_nxt;
  logic        cons_r, cons_nxt;
  logic [62:0] tag_r, tag_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [63:0] len_r, len_nxt;
  logic [3:0]  left_r, left_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDENT;
      class_r <= '0;
      cons_r  <= 1'b0;
      tag_r   <= '0;
      cnt_r   <= '0;
      len_r   <= '0;
      left_r  <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      class_r <= class_nxt;
      cons_r  <= cons_nxt;
      tag_r   <= tag_nxt;
      cnt_r   <= cnt_nxt;
      len_r   <= len_nxt;
      left_r  <= left_nxt;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    class_nxt = class_r;
    cons_nxt  = cons_r;
    tag_nxt   = tag_r;
    cnt_nxt   = cnt_r;
    len_nxt   = len_r;
    left_nxt  = left_r;
    emit      = 1'b0;
    res.tag_class      = class_r;
    res.constructed    = cons_r;
    res.tag_num        = tag_r;
    res.content_length = '0;
    res.indefinite     = 1'b0;
    res.status         = ST_OK;

    unique case (phase_r)
      PH_IDENT: begin
        class_nxt = data_byte[7:6];
        cons_nxt  = data_byte[5];
        cnt_nxt   = '0;
        if (data_byte[4:0] == TAG_LONG_FORM) begin
          tag_nxt   = '0;
          phase_nxt = PH_TAG;
        end else begin
          tag_nxt   = {58'd0, data_byte[4:0]};
          phase_nxt = PH_LEN;
        end
      end
      PH_TAG: begin
        tag_nxt = {tag_r[55:0], data_byte[6:0]};
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_nxt >= TAG_MAX_OCTETS) begin
          emit        = 1'b1;
          res.tag_num = '0;
          res.status  = ST_TAG_LONG;
          phase_nxt   = PH_IDENT;
        end else if (!data_byte[7]) begin
          phase_nxt = PH_LEN;
        end
      end
      PH_LEN: begin
        if (!data_byte[7]) begin
          emit               = 1'b1;
          res.content_length = {57'd0, data_byte[6:0]};
          phase_nxt          = PH_IDENT;
        end else if (data_byte[6:0] == LEN_INDEFINITE) begin
          emit           = 1'b1;
          res.indefinite = 1'b1;
          phase_nxt      = PH_IDENT;
        end else if (data_byte[6:0] > LEN_MAX_BYTES) begin
          emit       = 1'b1;
          res.status = ST_LEN_LONG;
          phase_nxt  = PH_IDENT;
        end else begin
          len_nxt   = '0;
          left_nxt  = data_byte[3:0];
          phase_nxt = PH_LENBYTES;
        end
      end
      PH_LENBYTES: begin
        len_nxt = {len_r[55:0], data_byte};
        if (left_r != 4'd0) begin
          left_nxt = left_r - 4'd1;
        end
        if (left_nxt == 4'd0) begin
          emit               = 1'b1;
          res.content_length = len_nxt;
          phase_nxt          = PH_IDENT;
        end
      end
      default: begin
        phase_nxt = PH_IDENT;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/core/ber_tlv_chk.sv -----
`default_nettype none

module ber_tlv_chk
  import ber_tlv_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [62:0] out_tag_num,
  input wire logic [63:0] out_content_length,
  input wire logic        out_indefinite,
  input wire logic [1:0]  out_status
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_tag_num)
      && $stable(out_content_length) && $stable(out_status))
    else $error("result beat changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_TAG_LONG
      || out_status == ST_LEN_LONG))
    else $error("unused status code");

  a_tag_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_TAG_LONG |->
      out_tag_num == '0 && out_content_length == '0 && !out_indefinite)
    else $error("tag error beat carries data");

  a_len_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_LEN_LONG |-> out_content_length == '0 && !out_indefinite)
    else $error("length error beat carries length");

  a_indef: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_indefinite |-> out_content_length == '0 && out_status == ST_OK)
    else $error("indefinite beat with length or error");

endmodule

bind ber_tlv_header_decoder ber_tlv_chk u_chk (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_bus.valid),
  .out_ready          (out_bus.ready),
  .out_tag_num        (out_bus.tag_num),
  .out_content_length (out_bus.content_length),
  .out_indefinite     (out_bus.indefinite),
  .out_status         (out_bus.status)
);

`default_nettype wire
